// ===== rtl/ctl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// C token lexer package
// Shared types, class codes and token tables for the byte-serial lexer.
// ---------------------------------------------------------------------------
package ctl_pkg;

  typedef enum logic [2:0] {
    CLS_NUMBER  = 3'd0,
    CLS_KEYWORD = 3'd1,
    CLS_IDENT   = 3'd2,
    CLS_OPER    = 3'd3,
    CLS_BADOP   = 3'd4,
    CLS_SPECIAL = 3'd5,
    CLS_COMMENT = 3'd6
  } tok_class_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_WORD  = 3'd2,
    MODE_OPS   = 3'd3,
    MODE_LINE  = 3'd4,
    MODE_BLOCK = 3'd5,
    MODE_STAR  = 3'd6
  } scan_mode_e;

  localparam int unsigned MaxTokenChars = 8;
  localparam int unsigned NumKeywords   = 32;
  localparam int unsigned NumOperators  = 27;

  typedef struct packed {
    logic       end_of_text;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic [7:0]  token_length;
    logic [63:0] token_text;
    logic [7:0]  code;
    logic [31:0] number_value;
    logic [2:0]  token_class;
  } out_item_t;

  // Result of a table match.
  typedef struct packed {
    logic       hit;
    logic [7:0] idx;
  } match_t;

  // Keyword texts, first character in the low byte, with lengths.
  function automatic logic [63:0] kw_text(input logic [4:0] i);
    logic [63:0] t;
    t = '0;
    case (i)
      5'd0:  t = 64'h6F747561;
      5'd1:  t = 64'h6B61657262;
      5'd2:  t = 64'h65736163;
      5'd3:  t = 64'h72616863;
      5'd4:  t = 64'h74736E6F63;
      5'd5:  t = 64'h65756E69746E6F63;
      5'd6:  t = 64'h746C7561666564;
      5'd7:  t = 64'h6F64;
      5'd8:  t = 64'h656C62756F64;
      5'd9:  t = 64'h65736C65;
      5'd10: t = 64'h6D756E65;
      5'd11: t = 64'h6E7265747865;
      5'd12: t = 64'h74616F6C66;
      5'd13: t = 64'h726F66;
      5'd14: t = 64'h6F746F67;
      5'd15: t = 64'h6669;
      5'd16: t = 64'h746E69;
      5'd17: t = 64'h676E6F6C;
      5'd18: t = 64'h7265747369676572;
      5'd19: t = 64'h6E7275746572;
      5'd20: t = 64'h74726F6873;
      5'd21: t = 64'h64656E676973;
      5'd22: t = 64'h666F657A6973;
      5'd23: t = 64'h636974617473;
      5'd24: t = 64'h746375727473;
      5'd25: t = 64'h686374697773;
      5'd26: t = 64'h66656465707974;
      5'd27: t = 64'h6E6F696E75;
      5'd28: t = 64'h64656E6769736E75;
      5'd29: t = 64'h64696F76;
      5'd30: t = 64'h656C6974616C6F76;
      5'd31: t = 64'h656C696877;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_len(input logic [4:0] i);
    logic [7:0] n;
    n = 8'd0;
    case (i)
      5'd7, 5'd15: n = 8'd2;
      5'd13, 5'd16: n = 8'd3;
      5'd0, 5'd2, 5'd3, 5'd9, 5'd10, 5'd14, 5'd17, 5'd29: n = 8'd4;
      5'd1, 5'd4, 5'd12, 5'd20, 5'd27, 5'd31: n = 8'd5;
      5'd8, 5'd11, 5'd19, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: n = 8'd6;
      5'd6, 5'd26: n = 8'd7;
      5'd5, 5'd18, 5'd28, 5'd30: n = 8'd8;
      default: n = 8'd0;
    endcase
    return n;
  endfunction

  // Operator texts; the entries holding '%' can never be matched.
  function automatic logic [15:0] op_text(input logic [4:0] i);
    logic [15:0] t;
    t = '0;
    case (i)
      5'd0:  t = 16'h002B;
      5'd1:  t = 16'h002D;
      5'd2:  t = 16'h002A;
      5'd3:  t = 16'h002F;
      5'd4:  t = 16'h0025;
      5'd5:  t = 16'h003D;
      5'd6:  t = 16'h0021;
      5'd7:  t = 16'h0026;
      5'd8:  t = 16'h007C;
      5'd9:  t = 16'h005E;
      5'd10: t = 16'h003E;
      5'd11: t = 16'h003C;
      5'd12: t = 16'h3D2B;
      5'd13: t = 16'h3D2D;
      5'd14: t = 16'h3D2A;
      5'd15: t = 16'h3D2F;
      5'd16: t = 16'h3D25;
      5'd17: t = 16'h3D3D;
      5'd18: t = 16'h3D21;
      5'd19: t = 16'h3D3E;
      5'd20: t = 16'h3D3C;
      5'd21: t = 16'h2626;
      5'd22: t = 16'h7C7C;
      5'd23: t = 16'h3C3C;
      5'd24: t = 16'h3E3E;
      5'd25: t = 16'h2B2B;
      5'd26: t = 16'h2D2D;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ctl_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// C token lexer table match
// Parallel compare of the pending token against the keyword and operator
// tables.
// ---------------------------------------------------------------------------
module ctl_match (
  input  logic [63:0]     text_i,
  input  logic [7:0]      len_i,
  output ctl_pkg::match_t kw_o,
  output ctl_pkg::match_t op_o
);
  import ctl_pkg::*;

  // Keyword compare: full length and packed text must agree.
  always_comb begin
    kw_o = '0;
    for (int i = NumKeywords - 1; i >= 0; i--) begin
      if (len_i == kw_len(5'(i)) && text_i == kw_text(5'(i))) begin
        kw_o.hit = 1'b1;
        kw_o.idx = 8'(i);
      end
    end
  end

  // Operator compare: single-byte entries have a zero high byte.
  always_comb begin
    logic [7:0]  olen;
    logic [15:0] otxt;
    op_o = '0;
    for (int i = NumOperators - 1; i >= 0; i--) begin
      otxt = op_text(5'(i));
      olen = (otxt[15:8] == 8'd0) ? 8'd1 : 8'd2;
      if (len_i == olen && text_i == {48'd0, otxt}) begin
        op_o.hit = 1'b1;
        op_o.idx = 8'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/c_token_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// C token lexer
// Byte-serial classifier of C source text into numbers, keywords,
// identifiers, operators, invalid operators, special symbols and line-comment characters.
// ---------------------------------------------------------------------------
// Channel  Direction  Payload     Handshake
// in       input      in_item_t   in_valid_i / in_ready_o
// out      output     out_item_t  out_valid_o / out_ready_i
//
// One byte is taken every cycle while the queue has room; the scan state
// updates in the cycle of the transfer and up to two results go into a
// two-entry output queue, the first offered in the cycle after the transfer.
// A byte is taken only when the queue has room for two results after any
// transfer out in the same cycle, so a single waiting result with the output
// side stalled holds the input.
// Reset returns the scanner to idle and empties the queue.
// ---------------------------------------------------------------------------
module c_token_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ctl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ctl_pkg::out_item_t out_data_o
);
  import ctl_pkg::*;

  scan_mode_e  mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [63:0] buf_q, buf_d;
  logic [7:0]  len_q, len_d;

  out_item_t   q0_q, q1_q, q0_d, q1_d;
  logic [1:0]  cnt_q, cnt_d;

  match_t      kw, op;
  logic        accept, pop;
  logic [7:0]  c;
  logic        is_dig, is_alp, is_op, is_ws;
  out_item_t   r0, r1;
  logic [1:0]  nres;

  ctl_match u_match (
    .text_i (buf_q),
    .len_i  (len_q),
    .kw_o   (kw),
    .op_o   (op)
  );

  assign in_ready_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i)
                       || (cnt_q == 2'd2 && out_ready_i && 1'b0);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = q0_q;

  assign c      = in_data_i.ch;
  assign is_dig = (c >= 8'd48) && (c <= 8'd57);
  assign is_alp = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign is_op  = (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3E, 8'h3C,
                             8'h21, 8'h26, 8'h7C, 8'h5E});
  assign is_ws  = (c inside {8'h20, 8'h09, 8'h0A});

  // Scan step: flush of the pending run, then handling of the byte itself.
  always_comb begin
    logic       pend, ext, do_flush, fl_emit;
    out_item_t  fr, br;
    logic       b_emit;
    scan_mode_e fl_mode, mode_b;
    logic [2:0] idx;

    mode_d = mode_q; acc_d = acc_q; buf_d = buf_q; len_d = len_q;
    r0 = '0; r1 = '0; nres = 2'd0;
    fr = '0; br = '0; b_emit = 1'b0; fl_emit = 1'b0; fl_mode = MODE_IDLE;
    idx = len_q[2:0];

    pend = (mode_q == MODE_NUM) || (mode_q == MODE_WORD) || (mode_q == MODE_OPS);
    case (mode_q)
      MODE_NUM:  ext = is_dig;
      MODE_WORD: ext = is_dig || is_alp || c == 8'h5F || c == 8'h24;
      MODE_OPS:  ext = is_op;
      default:   ext = 1'b0;
    endcase

    // Flushed token of the pending run.
    fr.token_text   = buf_q;
    fr.token_length = len_q;
    case (mode_q)
      MODE_NUM: begin
        fl_emit = 1'b1; fr.token_class = CLS_NUMBER; fr.number_value = acc_q;
      end
      MODE_WORD: begin
        fl_emit = 1'b1;
        fr.token_class = kw.hit ? CLS_KEYWORD : CLS_IDENT;
        fr.code = kw.hit ? kw.idx : 8'd0;
      end
      MODE_OPS: begin
        if (op.hit) begin
          fl_emit = 1'b1; fr.token_class = CLS_OPER; fr.code = op.idx;
        end else if (len_q == 8'd2 && buf_q == 64'h2F2F) begin
          fl_mode = MODE_LINE;
        end else if (len_q == 8'd2 && buf_q == 64'h2A2F) begin
          fl_mode = MODE_BLOCK;
        end else begin
          fl_emit = 1'b1; fr.token_class = CLS_BADOP;
        end
      end
      default: fl_mode = MODE_IDLE;
    endcase

    if (accept) begin
      if (in_data_i.end_of_text) begin
        if (pend && fl_emit) begin
          r0 = fr; nres = 2'd1;
        end
        mode_d = MODE_IDLE; acc_d = '0; buf_d = '0; len_d = '0;
      end else if (pend && ext) begin
        // Extend the current run.
        if (len_q < 8'(MaxTokenChars)) buf_d[idx*8 +: 8] = c;
        if (len_q != 8'hFF) len_d = len_q + 8'd1;
        if (mode_q == MODE_NUM) acc_d = (acc_q << 3) + (acc_q << 1) + {24'd0, c} - 32'd48;
      end else begin
        do_flush = pend;
        mode_b   = do_flush ? fl_mode : mode_q;
        br.token_text   = {56'd0, c};
        br.token_length = 8'd1;
        br.code         = c;
        mode_d = mode_b; acc_d = '0; buf_d = '0; len_d = '0;
        case (mode_b)
          MODE_LINE: begin
            if (c == 8'h0A) mode_d = MODE_IDLE;
            else begin b_emit = 1'b1; br.token_class = CLS_COMMENT; end
          end
          MODE_BLOCK: if (c == 8'h2A) mode_d = MODE_STAR;
          MODE_STAR: begin
            if (c == 8'h2F) mode_d = MODE_IDLE;
            else if (c != 8'h2A) mode_d = MODE_BLOCK;
          end
          default: begin
            mode_d = MODE_IDLE;
            if (is_dig) begin
              mode_d = MODE_NUM; acc_d = {24'd0, c} - 32'd48;
              buf_d = {56'd0, c}; len_d = 8'd1;
            end else if (is_alp) begin
              mode_d = MODE_WORD; buf_d = {56'd0, c}; len_d = 8'd1;
            end else if (is_op) begin
              mode_d = MODE_OPS; buf_d = {56'd0, c}; len_d = 8'd1;
            end else if (!is_ws) begin
              b_emit = 1'b1; br.token_class = CLS_SPECIAL;
            end
          end
        endcase
        if (do_flush && fl_emit) begin
          r0 = fr;
          if (b_emit) begin r1 = br; nres = 2'd2; end
          else nres = 2'd1;
        end else if (b_emit) begin
          r0 = br; nres = 2'd1;
        end
      end
      if (nres == 2'd1) r0.last = 1'b1;
      if (nres == 2'd2) r1.last = 1'b1;
    end
  end

  // Output queue: pop from the head, then append new results.
  always_comb begin
    out_item_t a0, a1;
    logic [1:0] n;
    a0 = q0_q; a1 = q1_q; n = cnt_q;
    if (pop) begin a0 = q1_q; n = cnt_q - 2'd1; end
    q0_d = a0; q1_d = a1;
    case (n)
      2'd0: begin
        if (nres != 2'd0) q0_d = r0;
        if (nres == 2'd2) q1_d = r1;
      end
      2'd1: if (nres != 2'd0) q1_d = r0;
      default: q1_d = a1;
    endcase
    cnt_d = n + nres;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      buf_q  <= '0;
      len_q  <= '0;
      cnt_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      buf_q  <= buf_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output queue overflow");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("input taken with full queue");
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_text |=> mode_q == MODE_IDLE && len_q == 8'd0)
    else $error("end of text did not reset the scanner");
`endif

endmodule
`default_nettype wire
